### rtl/wbss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner package
// Item codes and the command and status groups shared by the controller
// and the datapath.
// ----------------------------------------------------------------------------
package wbss_pkg;

  // Item kinds carried in the input tuser field.
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_SCAN    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // capture the accepted beat and apply its action
    logic step;   // issue one pattern and window read
    logic eval;   // resolve the match of the finished compare sweep
    logic emit;   // load the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_test;  // the beat at the input starts a compare sweep
    logic last_step;  // the read being issued is the last of the sweep
    logic out_free;   // the output register can take a result
  } dp_sts_t;

endpackage
`default_nettype wire

### rtl/wbss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner controller
// Sequences one item at a time: accept, compare and resolve if tested, emit.
// ----------------------------------------------------------------------------
module wbss_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire wbss_pkg::dp_sts_t sts_i,
  output wbss_pkg::dp_cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EVAL = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = sts_i.need_test ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.last_step) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

### rtl/wbss_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner datapath
// Pattern memory, circular byte window memory, scan counters, the
// masked compare and the output register.
// ----------------------------------------------------------------------------
module wbss_datapath #(
  parameter int MAX_PATTERN = 128,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wbss_pkg::dp_cmd_t cmd_i,
  output wbss_pkg::dp_sts_t      sts_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [6:0]        pattern_index_i,
  input  wire logic [7:0]        pattern_byte_i,
  input  wire logic              pattern_wild_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  input  wire logic              cfg_we_i,
  input  wire logic [7:0]        cfg_wdata_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   hit_o,
  output logic                   found_o,
  output logic [31:0]            match_offset_o,
  output logic                   done_res_o
);

  localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LW = $clog2(MAX_PATTERN + 1);
  localparam int OW = OFFSET_BITS;

  localparam logic [PW-1:0] PtrLast = PW'(MAX_PATTERN - 1);
  localparam logic [LW-1:0] LenMax  = LW'(MAX_PATTERN);

  // Memories: pattern entries (wildcard mark on top) and window bytes.
  logic [8:0] pat_mem [MAX_PATTERN];
  logic [7:0] win_mem [MAX_PATTERN];

  logic [7:0]    len_cfg_q;
  logic [PW-1:0] wptr_q;
  logic [LW-1:0] fill_q;
  logic [OW-1:0] seen_q;
  logic [OW-1:0] offset_q;
  logic          found_q;
  logic          done_q;
  logic          last_q;
  logic          hit_q;
  logic          match_q;
  logic          rd_vld_q;
  logic [PW-1:0] j_q;
  logic [PW-1:0] rptr_q;
  logic [8:0]    pat_rd_q;
  logic [7:0]    win_rd_q;

  logic          out_valid_q;
  logic          out_hit_q;
  logic          out_found_q;
  logic [31:0]   out_offset_q;
  logic          out_done_q;

  logic [LW-1:0] len;
  logic [PW-1:0] len_m1;
  logic [PW-1:0] wptr_nxt;
  logic [PW-1:0] rptr_start;
  logic [PW:0]   start_wrap;
  logic [LW-1:0] fill_nxt;
  logic          cmp_ok;
  logic          match_final;
  logic          scan_live;
  logic          pat_we;

  // Active length: zero acts as one, above the depth acts as the depth.
  always_comb begin
    if (len_cfg_q == 8'd0) begin
      len = LW'(1);
    end else if (32'(len_cfg_q) > MAX_PATTERN) begin
      len = LenMax;
    end else begin
      len = LW'(len_cfg_q);
    end
  end

  assign len_m1   = PW'(len - LW'(1));
  assign wptr_nxt = (wptr_q == PtrLast) ? '0 : wptr_q + PW'(1);
  assign fill_nxt = (fill_q == LenMax) ? fill_q : fill_q + LW'(1);

  // Oldest window position of the compare, modulo the window depth.
  assign start_wrap = {1'b0, wptr_nxt} + (PW + 1)'(MAX_PATTERN) - {1'b0, len_m1};
  assign rptr_start = (wptr_nxt >= len_m1) ? (wptr_nxt - len_m1) : start_wrap[PW-1:0];

  // Masked byte compare on the registered read data.
  assign cmp_ok      = pat_rd_q[8] | (pat_rd_q[7:0] == win_rd_q);
  assign match_final = match_q & cmp_ok;

  assign scan_live = (op_i == wbss_pkg::OP_SCAN) && !done_q;

  // A load beat with an index inside the store writes one entry.
  assign pat_we = cmd_i.take && (op_i == wbss_pkg::OP_LOAD) &&
                  (32'(pattern_index_i) < MAX_PATTERN);

  // Status toward the controller.
  assign sts_o.need_test = scan_live && (fill_nxt >= len);
  assign sts_o.last_step = (j_q == len_m1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // Pattern memory write and read port.
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[PW'(pattern_index_i)] <= {pattern_wild_i, pattern_byte_i};
    end
    if (cmd_i.step) begin
      pat_rd_q <= pat_mem[j_q];
    end
  end

  // Window memory write and read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take && scan_live) begin
      win_mem[wptr_nxt] <= data_byte_i;
    end
    if (cmd_i.step) begin
      win_rd_q <= win_mem[rptr_q];
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= 8'd1;
    end else if (cfg_we_i) begin
      len_cfg_q <= cfg_wdata_i;
    end
  end

  // Scan state and compare sweep.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q   <= '0;
      fill_q   <= '0;
      seen_q   <= '0;
      offset_q <= '0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      last_q   <= 1'b0;
      hit_q    <= 1'b0;
      match_q  <= 1'b0;
      rd_vld_q <= 1'b0;
      j_q      <= '0;
      rptr_q   <= '0;
    end else begin
      if (cmd_i.take) begin
        hit_q    <= 1'b0;
        rd_vld_q <= 1'b0;
        last_q   <= last_byte_i;
        unique case (op_i)
          wbss_pkg::OP_SCAN: begin
            if (!done_q) begin
              wptr_q <= wptr_nxt;
              fill_q <= fill_nxt;
              seen_q <= seen_q + OW'(1);
              if (fill_nxt >= len) begin
                j_q     <= '0;
                rptr_q  <= rptr_start;
                match_q <= 1'b1;
              end else if (last_byte_i) begin
                done_q <= 1'b1;
              end
            end
          end
          wbss_pkg::OP_RESTART: begin
            fill_q   <= '0;
            seen_q   <= '0;
            offset_q <= '0;
            found_q  <= 1'b0;
            done_q   <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      // One read a cycle; the previous read is folded into the match.
      if (cmd_i.step) begin
        rd_vld_q <= 1'b1;
        j_q      <= j_q + PW'(1);
        rptr_q   <= (rptr_q == PtrLast) ? '0 : rptr_q + PW'(1);
        if (rd_vld_q) begin
          match_q <= match_final;
        end
      end
      // The last read resolves the match.
      if (cmd_i.eval) begin
        hit_q <= match_final;
        if (match_final) begin
          found_q  <= 1'b1;
          offset_q <= seen_q - OW'(len);
        end
        if (match_final || last_q) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_hit_q    <= hit_q;
      out_found_q  <= found_q;
      out_offset_q <= 32'(offset_q);
      out_done_q   <= done_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_o          = out_hit_q;
  assign found_o        = out_found_q;
  assign match_offset_o = out_offset_q;
  assign done_res_o     = out_done_q;

endmodule
`default_nettype wire

### rtl/wildcard_byte_signature_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A load, restart or untested scan beat goes from acceptance to the emit state, and its
// result is registered once the output register is free. A scan beat that tests a match
// first makes one pattern and window read per signature entry from the single-port
// memories, then resolves and emits. The core takes one beat at a time.
// Reset: asynchronous active low; clears the scan, sets the length to 1.
// The pattern memory is not cleared and holds nothing until loaded.
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner core
// Streams an image against a loaded signature with wildcard entries and
// reports the first match and its start offset.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_core #(
  parameter int MAX_PATTERN = 128,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,      // pattern_length
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // pattern_index[6:0], pattern_byte[14:7], pattern_wild[15], data_byte[23:16]
  input  wire logic [23:0] s_axis_tdata_i,
  input  wire logic [1:0]  s_axis_tuser_i,   // op[1:0]
  input  wire logic        s_axis_tlast_i,   // last_byte
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // hit[0], found[1], match_offset[33:2], done_res[34], zero[39:35]
  output logic [39:0]      m_axis_tdata_o
);

  wbss_pkg::dp_cmd_t cmd;
  wbss_pkg::dp_sts_t sts;

  logic        hit;
  logic        found;
  logic [31:0] match_offset;
  logic        done_res;

  // Controller.
  wbss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  wbss_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (s_axis_tuser_i),
    .pattern_index_i (s_axis_tdata_i[6:0]),
    .pattern_byte_i  (s_axis_tdata_i[14:7]),
    .pattern_wild_i  (s_axis_tdata_i[15]),
    .data_byte_i     (s_axis_tdata_i[23:16]),
    .last_byte_i     (s_axis_tlast_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .hit_o           (hit),
    .found_o         (found),
    .match_offset_o  (match_offset),
    .done_res_o      (done_res)
  );

  // Result beat packing.
  assign m_axis_tdata_o = {5'b0, done_res, match_offset, found, hit};

endmodule
`default_nettype wire

### rtl/wbss_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner checker
// Port-level assertions on result beats and input flow, bound to the core.
// ----------------------------------------------------------------------------
module wbss_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [39:0] m_axis_tdata_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // A hit always comes with found and done.
  a_hit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[1] && m_axis_tdata_o[34])
    else $error("hit without found and done");

  // A found scan is always finished.
  a_found_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[1] |-> m_axis_tdata_o[34])
    else $error("found without done");

  // The offset reads zero until a match is found.
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[1] |-> m_axis_tdata_o[33:2] == 32'd0)
    else $error("offset set without a match");

  // The core works on one beat at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while busy");

endmodule

bind wildcard_byte_signature_scanner_core wbss_checker u_wbss_checker (.*);
`default_nettype wire

### tb/sv/wbss_match_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Signature scanner match checker
// Watches the length register port and both stream channels. It keeps its own
// copy of the signature, the sliding byte window and the scan flags, predicts
// one report per accepted input beat and compares every output beat with the
// oldest prediction.
// ----------------------------------------------------------------------------
module wbss_match_checker #(
  parameter int SIG_DEPTH = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,   // pattern_length
  input  wire logic        in_tvalid_i,
  input  wire logic        in_tready_i,
  // pattern_index[6:0], pattern_byte[14:7], pattern_wild[15], data_byte[23:16]
  input  wire logic [23:0] in_tdata_i,
  input  wire logic [1:0]  in_tuser_i,    // op[1:0]
  input  wire logic        in_tlast_i,    // last_byte
  input  wire logic        out_tvalid_i,
  input  wire logic        out_tready_i,
  // hit[0], found[1], match_offset[33:2], done_res[34], zero[39:35]
  input  wire logic [39:0] out_tdata_i,
  output int               fail_count_o,
  output int               pending_o
);

  // One scan report, laid out as in the output beat (hit in bit 0).
  typedef struct packed {
    logic        done;
    logic [31:0] offset;
    logic        found;
    logic        hit;
  } scan_report_t;

  logic [8:0]   sig_mem [SIG_DEPTH];  // bit 8 is the wildcard mark
  logic [7:0]   win_mem [SIG_DEPTH];  // entry k is the byte seen k beats ago
  logic [31:0]  bytes_taken;
  logic [31:0]  match_start;
  logic         match_seen;
  logic         scan_over;
  int           win_fill;
  logic [7:0]   sig_len;
  scan_report_t report_q [$];
  int           fails;

  // Length in use: zero acts as one, anything past the store depth saturates.
  function automatic int active_len();
    if (sig_len == 8'd0) return 1;
    if (int'(sig_len) > SIG_DEPTH) return SIG_DEPTH;
    return int'(sig_len);
  endfunction

  // The newest n window bytes against the first n signature entries.
  function automatic logic window_hit(input int n);
    for (int j = 0; j < n; j++) begin
      if (!sig_mem[j][8] && win_mem[n - 1 - j] != sig_mem[j][7:0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic clear_scan();
    for (int k = 0; k < SIG_DEPTH; k++) win_mem[k] = 8'h00;
    bytes_taken = '0;
    match_start = '0;
    match_seen  = 1'b0;
    scan_over   = 1'b0;
    win_fill    = 0;
  endtask

  // Apply one accepted input beat and queue the report it must produce.
  task automatic take_item(input logic [1:0] op, input logic [23:0] data,
                           input logic last);
    scan_report_t rep;
    int           n;
    rep = '0;
    case (op)
      wbss_pkg::OP_LOAD: begin
        sig_mem[data[6:0]] = data[15:7];
      end
      wbss_pkg::OP_SCAN: begin
        // Bytes that arrive after the scan has finished change nothing.
        if (!scan_over) begin
          n = active_len();
          for (int k = SIG_DEPTH - 1; k > 0; k--) win_mem[k] = win_mem[k - 1];
          win_mem[0] = data[23:16];
          bytes_taken++;
          if (win_fill < SIG_DEPTH) win_fill++;
          if (win_fill >= n && window_hit(n)) begin
            rep.hit     = 1'b1;
            match_seen  = 1'b1;
            match_start = bytes_taken - 32'(n);
            scan_over   = 1'b1;
          end
          if (last) scan_over = 1'b1;
        end
      end
      wbss_pkg::OP_RESTART: begin
        clear_scan();
      end
      default: ;
    endcase
    rep.found  = match_seen;
    rep.offset = match_start;
    rep.done   = scan_over;
    report_q.insert(report_q.size(), rep);
  endtask

  // Compare output beats first, then record the input beat of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch_beats
    scan_report_t got;
    scan_report_t want;
    if (!rst_ni) begin
      clear_scan();
      for (int k = 0; k < SIG_DEPTH; k++) sig_mem[k] = '0;
      sig_len = 8'd1;
      report_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) sig_len = cfg_wdata_i;
      if (out_tvalid_i && out_tready_i) begin
        got = scan_report_t'(out_tdata_i[34:0]);
        if (report_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected result beat, nothing predicted, got %h",
                   $time, out_tdata_i);
        end else begin
          want = report_q.pop_front();
          if (got !== want || out_tdata_i[39:35] !== 5'd0) begin
            fails++;
            $display("%0t: result differs: expected hit=%0b found=%0b offset=%0d done=%0b",
                     $time, want.hit, want.found, want.offset, want.done);
            $display("%0t:                  actual hit=%0b found=%0b offset=%0d done=%0b pad=%h",
                     $time, got.hit, got.found, got.offset, got.done, out_tdata_i[39:35]);
          end
        end
      end
      if (in_tvalid_i && in_tready_i) take_item(in_tuser_i, in_tdata_i, in_tlast_i);
      fail_count_o <= fails;
      pending_o    <= report_q.size();
    end
  end

endmodule

### tb/sv/wildcard_byte_signature_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard byte signature scanner testbench
// Loads signatures with wildcard entries, streams images with planted and
// chance matches under several length settings and random stalls on both
// sides, and lets the match checker judge every report beat.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scanner_core_tb;

  localparam logic [1:0] OP_UNUSED      = 2'd3;
  localparam int         SIG_DEPTH      = 128;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         PHASE_BEATS    = 100;
  localparam int         NUM_PHASES     = 15;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [7:0]  cfg_wdata_i     = 8'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // pattern_index[6:0], pattern_byte[14:7], pattern_wild[15], data_byte[23:16]
  logic [23:0] s_axis_tdata_i  = '0;
  logic [1:0]  s_axis_tuser_i  = wbss_pkg::OP_LOAD;   // op[1:0]
  logic        s_axis_tlast_i  = 1'b0;                // last_byte
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // hit[0], found[1], match_offset[33:2], done_res[34], zero[39:35]
  logic [39:0] m_axis_tdata_o;

  int fail_count;
  int pending;

  int sender_idle_pct   = 36;
  int receiver_idle_pct = 68;
  int rx_hold_cycles    = 0;
  int phase_beats       = 0;
  int eff_len           = 1;

  // Stimulus-side copy of what has been loaded, used to plant matches.
  bit [7:0] sig_byte   [SIG_DEPTH];
  bit       sig_wild   [SIG_DEPTH];
  bit       sig_loaded [SIG_DEPTH];

  logic [7:0] phase_len [NUM_PHASES] = '{8'd1, 8'd2, 8'd0, 8'd4, 8'd128, 8'd3, 8'd5,
                                         8'd255, 8'd1, 8'd8, 8'd6, 8'd200, 8'd2,
                                         8'd16, 8'd7};

  wildcard_byte_signature_scanner_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  wbss_match_checker #(
    .SIG_DEPTH (SIG_DEPTH)
  ) u_match_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_tvalid_i  (s_axis_tvalid_i),
    .in_tready_i  (s_axis_tready_o),
    .in_tdata_i   (s_axis_tdata_i),
    .in_tuser_i   (s_axis_tuser_i),
    .in_tlast_i   (s_axis_tlast_i),
    .out_tvalid_i (m_axis_tvalid_o),
    .out_tready_i (m_axis_tready_i),
    .out_tdata_i  (m_axis_tdata_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Report side: random stalls, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        rx_hold_cycles--;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  // Ends the run if neither channel moves a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one beat after a random gap and hold it until it is taken.
  task automatic offer_beat(input logic [1:0] op, input logic [6:0] idx,
                            input logic [7:0] pbyte, input logic pwild,
                            input logic [7:0] dbyte, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {dbyte, pwild, pbyte, idx};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (op != OP_UNUSED) phase_beats++;
  endtask

  task automatic load_entry(input logic [6:0] idx, input logic [7:0] b, input logic w);
    sig_byte[idx]   = b;
    sig_wild[idx]   = w;
    sig_loaded[idx] = 1'b1;
    offer_beat(wbss_pkg::OP_LOAD, idx, b, w, 8'($urandom), 1'($urandom));
  endtask

  task automatic scan_byte(input logic [7:0] b, input logic last);
    offer_beat(wbss_pkg::OP_SCAN, 7'($urandom), 8'($urandom), 1'($urandom), b, last);
  endtask

  task automatic restart_scan();
    offer_beat(wbss_pkg::OP_RESTART, 7'($urandom), 8'($urandom), 1'($urandom),
               8'($urandom), 1'($urandom));
  endtask

  // Stop offering and wait until every predicted report has come back.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // The length register is only written with the block idle.
  task automatic set_length(input logic [7:0] value);
    drain_results();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    eff_len = (value == 8'd0) ? 1 : ((int'(value) > SIG_DEPTH) ? SIG_DEPTH : int'(value));
  endtask

  // Image bytes lean toward values that the signature holds, so chance
  // matches happen as well as planted ones.
  function automatic logic [7:0] image_byte();
    int pick;
    pick = $urandom_range(3);
    if (pick == 0) return sig_byte[$urandom_range(eff_len - 1)];
    if (pick == 1) return ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
    return 8'($urandom_range(255));
  endfunction

  // One image: random prefix, mostly a planted signature, a short tail, and
  // usually a closing last byte. Now and then an unused op or a reload.
  task automatic run_image();
    logic [7:0] img [$];
    int         prefix;
    logic       close;
    if ($urandom_range(99) < 85) restart_scan();
    prefix = (eff_len > 16) ? $urandom_range(eff_len / 4) : $urandom_range(2 * eff_len + 4);
    repeat (prefix) img.insert(img.size(), image_byte());
    if ($urandom_range(99) < 70) begin
      for (int j = 0; j < eff_len; j++) begin
        img.insert(img.size(), sig_wild[j] ? image_byte() : sig_byte[j]);
      end
    end
    repeat ($urandom_range(2)) img.insert(img.size(), image_byte());
    if (img.size() == 0) img.insert(img.size(), image_byte());
    close = ($urandom_range(99) < 85);
    foreach (img[i]) begin
      if ($urandom_range(49) == 0) begin
        offer_beat(OP_UNUSED, 7'($urandom), 8'($urandom), 1'($urandom), 8'($urandom),
                   1'($urandom));
      end else if ($urandom_range(49) == 0) begin
        load_entry(7'($urandom_range(SIG_DEPTH - 1)), 8'($urandom), 1'($urandom));
      end
      scan_byte(img[i], close && (i == img.size() - 1));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: unused op, restart on a fresh scan, a plain match, bytes after
    // done, an image ending without a match, a wildcard match, extreme
    // indexes, a short image, and a match on the last byte.
    offer_beat(OP_UNUSED, 7'h7F, 8'hFF, 1'b1, 8'hFF, 1'b1);
    restart_scan();
    load_entry(7'd0, 8'hFF, 1'b0);
    scan_byte(8'h00, 1'b0);
    scan_byte(8'hFF, 1'b0);
    scan_byte(8'hFF, 1'b1);
    restart_scan();
    scan_byte(8'h12, 1'b1);
    restart_scan();
    load_entry(7'd0, 8'h00, 1'b1);
    scan_byte(8'h5A, 1'b0);
    load_entry(7'd127, 8'hAA, 1'b1);
    load_entry(7'd1, 8'h00, 1'b0);
    set_length(8'd2);
    restart_scan();
    scan_byte(8'h00, 1'b0);
    scan_byte(8'h00, 1'b1);
    restart_scan();
    scan_byte(8'h01, 1'b0);
    scan_byte(8'h02, 1'b0);
    scan_byte(8'h00, 1'b1);

    // Random phases, each under its own length setting.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 5) begin
        sender_idle_pct   = 68;
        receiver_idle_pct = 36;
      end
      if (p == 10) begin
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
      end
      set_length(phase_len[p]);
      // Every entry in use must be loaded before a window is compared.
      for (int i = 0; i < eff_len; i++) begin
        if (!sig_loaded[i]) load_entry(7'(i), 8'($urandom), $urandom_range(3) == 0);
      end
      repeat ($urandom_range(4)) begin
        load_entry(7'($urandom_range(eff_len - 1)), 8'($urandom), $urandom_range(3) == 0);
      end
      // Long receiver hold-off so the block backs up into its input.
      if (p == 3) rx_hold_cycles = HOLD_CYCLES;
      phase_beats = 0;
      if (p == 8) begin
        run_image();
        drain_results();
      end
      do begin
        run_image();
      end while (phase_beats < PHASE_BEATS);
    end

    drain_results();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
rtl/wbss_pkg.sv
rtl/wbss_ctrl.sv
rtl/wbss_datapath.sv
rtl/wildcard_byte_signature_scanner_core.sv
rtl/wbss_checker.sv
tb/sv/wbss_match_checker.sv
tb/sv/wildcard_byte_signature_scanner_core_tb.sv
